FILE: src/ldwt_pkg.sv
// Shared types and constants for the 5/3 lifting line transform.
// Used by every module under src/ except ldwt_ram; depends on nothing else.
`default_nettype none

package ldwt_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned DataW         = 32;

  typedef logic [DataW-1:0] word_t;

  // One input transaction: a sample (or coefficient) and the end-of-line mark.
  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    last;
  } ldwt_in_t;

  // One output transaction.
  typedef struct packed {
    logic signed [DataW-1:0] coefficient;
    logic                    last_res;
    logic                    overflow;
  } ldwt_out_t;

  // Request to the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    word_t a;
    word_t b;
    logic  sub;
  } ldwt_alu_req_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    ldwt_out_t item;
  } ldwt_emit_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_F_P_RDE,
    ST_F_P_RDR,
    ST_F_P_RDO,
    ST_F_P_ADD,
    ST_F_P_SUB,
    ST_F_U_RDL,
    ST_F_U_RDR,
    ST_F_U_ADD1,
    ST_F_U_ADD2,
    ST_F_U_ADD3,
    ST_I_U_RDL,
    ST_I_U_RDR,
    ST_I_U_RDX,
    ST_I_U_ADD1,
    ST_I_U_ADD2,
    ST_I_U_SUB,
    ST_I_P_RDA,
    ST_I_P_RDB,
    ST_I_P_ADD,
    ST_I_P_EMITE,
    ST_I_P_EMITO,
    ST_I_T_RD,
    ST_I_T_EMIT,
    ST_E_RD,
    ST_E_EMIT
  } ldwt_state_e;

  localparam word_t RoundTwo = word_t'(2);

endpackage

`default_nettype wire

FILE: src/ldwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module ldwt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/ldwt_alu.sv
// Shared 32-bit add/subtract unit used by every lifting step.
// Depends on ldwt_pkg.
`default_nettype none

module ldwt_alu
  import ldwt_pkg::*;
(
  input  wire ldwt_alu_req_t req_i,
  output word_t              res_o
);

  word_t b_op;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign res_o = req_i.a + b_op + word_t'(req_i.sub);

endmodule

`default_nettype wire

FILE: src/ldwt_seq.sv
// Line loader and lifting sequencer: walks the stores, drives the shared adder,
// hands results to the output register. Depends on ldwt_pkg.
`default_nettype none

module ldwt_seq
  import ldwt_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          dir_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ldwt_in_t      in_data_i,
  output logic               line_we_o,
  output logic [AW-1:0]      line_waddr_o,
  output word_t              line_wdata_o,
  output logic [AW-1:0]      line_raddr_o,
  input  wire word_t         line_rdata_i,
  output logic               scr_we_o,
  output logic [AW-1:0]      scr_waddr_o,
  output word_t              scr_wdata_o,
  output logic [AW-1:0]      scr_raddr_o,
  input  wire word_t         scr_rdata_i,
  output ldwt_alu_req_t      alu_req_o,
  input  wire word_t         alu_res_i,
  input  wire logic          out_free_i,
  output ldwt_emit_t         emit_o
);

  localparam int unsigned NW = $clog2(MAX_LEN + 1);
  localparam int unsigned IW = NW + 1;

  ldwt_state_e state_q, state_d;

  logic [NW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [NW-1:0] n_q, n_d;
  logic          ovfl_q, ovfl_d;
  logic          dir_q, dir_d;
  logic [IW-1:0] i_q, i_d;
  logic [NW-1:0] k_q, k_d;
  word_t         a_q, a_d, b_q, b_d, c_q, c_d, t_q, t_d;

  logic [IW-1:0] n_ext, sn, dn, two_i, i_m1, i_hr, i_p1;
  logic          room, last_dn, last_sn, n_small, k_last;

  function automatic logic [AW-1:0] adr(input logic [IW-1:0] x);
    return x[AW-1:0];
  endfunction

  function automatic word_t asr1(input word_t v);
    return {v[DataW-1], v[DataW-1:1]};
  endfunction

  function automatic word_t asr2(input word_t v);
    return {{2{v[DataW-1]}}, v[DataW-1:2]};
  endfunction

  assign n_ext   = IW'(n_q);
  assign sn      = (n_ext + IW'(1)) >> 1;
  assign dn      = n_ext >> 1;
  assign two_i   = {i_q[IW-2:0], 1'b0};
  assign i_m1    = (i_q != '0) ? i_q - IW'(1) : '0;
  assign i_hr    = (i_q < dn) ? i_q : dn - IW'(1);
  assign i_p1    = ((i_q + IW'(1)) < sn) ? i_q + IW'(1) : sn - IW'(1);
  assign last_dn = (i_q + IW'(1)) == dn;
  assign last_sn = (i_q + IW'(1)) == sn;
  assign room    = fill_q < NW'(MAX_LEN);
  assign n_small = n_q < NW'(2);
  assign k_last  = (k_q + NW'(1)) == n_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:      if (in_valid_i && in_data_i.last) state_d = ST_START;
      ST_START: begin
        if (n_small)     state_d = ST_E_RD;
        else if (dir_q)  state_d = ST_I_U_RDL;
        else             state_d = ST_F_P_RDE;
      end
      ST_F_P_RDE:   state_d = ST_F_P_RDR;
      ST_F_P_RDR:   state_d = ST_F_P_RDO;
      ST_F_P_RDO:   state_d = ST_F_P_ADD;
      ST_F_P_ADD:   state_d = ST_F_P_SUB;
      ST_F_P_SUB:   state_d = last_dn ? ST_F_U_RDL : ST_F_P_RDE;
      ST_F_U_RDL:   state_d = ST_F_U_RDR;
      ST_F_U_RDR:   state_d = ST_F_U_ADD1;
      ST_F_U_ADD1:  state_d = ST_F_U_ADD2;
      ST_F_U_ADD2:  state_d = ST_F_U_ADD3;
      ST_F_U_ADD3:  state_d = last_sn ? ST_E_RD : ST_F_U_RDL;
      ST_I_U_RDL:   state_d = ST_I_U_RDR;
      ST_I_U_RDR:   state_d = ST_I_U_RDX;
      ST_I_U_RDX:   state_d = ST_I_U_ADD1;
      ST_I_U_ADD1:  state_d = ST_I_U_ADD2;
      ST_I_U_ADD2:  state_d = ST_I_U_SUB;
      ST_I_U_SUB:   state_d = last_sn ? ST_I_P_RDA : ST_I_U_RDL;
      ST_I_P_RDA:   state_d = ST_I_P_RDB;
      ST_I_P_RDB:   state_d = ST_I_P_ADD;
      ST_I_P_ADD:   state_d = ST_I_P_EMITE;
      ST_I_P_EMITE: if (out_free_i) state_d = ST_I_P_EMITO;
      ST_I_P_EMITO: begin
        if (out_free_i) begin
          if (!last_dn)     state_d = ST_I_P_RDA;
          else if (n_q[0])  state_d = ST_I_T_RD;
          else              state_d = ST_LOAD;
        end
      end
      ST_I_T_RD:    state_d = ST_I_T_EMIT;
      ST_I_T_EMIT:  if (out_free_i) state_d = ST_LOAD;
      ST_E_RD:      state_d = ST_E_EMIT;
      ST_E_EMIT:    if (out_free_i) state_d = k_last ? ST_LOAD : ST_E_RD;
      default:      state_d = ST_LOAD;
    endcase
  end

  // Datapath control and register next values.
  always_comb begin
    in_ready_o   = 1'b0;
    line_we_o    = 1'b0;
    line_waddr_o = fill_q[AW-1:0];
    line_wdata_o = in_data_i.sample;
    line_raddr_o = '0;
    scr_we_o     = 1'b0;
    scr_waddr_o  = '0;
    scr_wdata_o  = alu_res_i;
    scr_raddr_o  = '0;
    alu_req_o    = '{a: a_q, b: b_q, sub: 1'b0};
    emit_o       = '0;
    emit_o.item.overflow = ovfl_q;
    fill_d = fill_q;
    ovf_d  = ovf_q;
    n_d    = n_q;
    ovfl_d = ovfl_q;
    dir_d  = dir_q;
    i_d    = i_q;
    k_d    = k_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    t_d    = t_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // store while there is room, drop and flag otherwise
          if (room) begin
            line_we_o = 1'b1;
            fill_d    = fill_q + NW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            n_d    = room ? fill_q + NW'(1) : fill_q;
            ovfl_d = ovf_q | ~room;
            dir_d  = dir_i;
            fill_d = '0;
            ovf_d  = 1'b0;
          end
        end
      end
      ST_START: begin
        i_d = '0;
        k_d = '0;
      end
      // forward predict: hi[i] = x[2i+1] - ((x[2i] + x[2i+2]) >>> 1)
      ST_F_P_RDE: line_raddr_o = adr(two_i);
      ST_F_P_RDR: begin
        line_raddr_o = ((two_i + IW'(2)) < n_ext) ? adr(two_i + IW'(2)) : adr(two_i);
        a_d = line_rdata_i;
      end
      ST_F_P_RDO: begin
        line_raddr_o = adr(two_i + IW'(1));
        b_d = line_rdata_i;
      end
      ST_F_P_ADD: begin
        c_d = line_rdata_i;
        t_d = alu_res_i;
      end
      ST_F_P_SUB: begin
        alu_req_o   = '{a: c_q, b: asr1(t_q), sub: 1'b1};
        scr_we_o    = 1'b1;
        scr_waddr_o = adr(sn + i_q);
        i_d         = last_dn ? '0 : i_q + IW'(1);
      end
      // forward update: lo[i] = x[2i] + ((hi[i-1] + hi[i] + 2) >>> 2)
      ST_F_U_RDL: scr_raddr_o = adr(sn + i_m1);
      ST_F_U_RDR: begin
        scr_raddr_o  = adr(sn + i_hr);
        line_raddr_o = adr(two_i);
        a_d = scr_rdata_i;
      end
      ST_F_U_ADD1: begin
        alu_req_o = '{a: a_q, b: scr_rdata_i, sub: 1'b0};
        t_d = alu_res_i;
        c_d = line_rdata_i;
      end
      ST_F_U_ADD2: begin
        alu_req_o = '{a: t_q, b: RoundTwo, sub: 1'b0};
        t_d = alu_res_i;
      end
      ST_F_U_ADD3: begin
        alu_req_o   = '{a: c_q, b: asr2(t_q), sub: 1'b0};
        scr_we_o    = 1'b1;
        scr_waddr_o = adr(i_q);
        i_d         = last_sn ? '0 : i_q + IW'(1);
      end
      // inverse update: lo'[i] = lo[i] - ((hi[i-1] + hi[i] + 2) >>> 2)
      ST_I_U_RDL: line_raddr_o = adr(sn + i_m1);
      ST_I_U_RDR: begin
        line_raddr_o = adr(sn + i_hr);
        a_d = line_rdata_i;
      end
      ST_I_U_RDX: begin
        line_raddr_o = adr(i_q);
        b_d = line_rdata_i;
      end
      ST_I_U_ADD1: begin
        c_d = line_rdata_i;
        t_d = alu_res_i;
      end
      ST_I_U_ADD2: begin
        alu_req_o = '{a: t_q, b: RoundTwo, sub: 1'b0};
        t_d = alu_res_i;
      end
      ST_I_U_SUB: begin
        alu_req_o   = '{a: c_q, b: asr2(t_q), sub: 1'b1};
        scr_we_o    = 1'b1;
        scr_waddr_o = adr(i_q);
        i_d         = last_sn ? '0 : i_q + IW'(1);
      end
      // inverse predict, emitted in sample order as it goes
      ST_I_P_RDA: scr_raddr_o = adr(i_q);
      ST_I_P_RDB: begin
        scr_raddr_o  = adr(i_p1);
        line_raddr_o = adr(sn + i_q);
        a_d = scr_rdata_i;
      end
      ST_I_P_ADD: begin
        alu_req_o = '{a: a_q, b: scr_rdata_i, sub: 1'b0};
        c_d = line_rdata_i;
        t_d = alu_res_i;
      end
      ST_I_P_EMITE: begin
        if (out_free_i) begin
          emit_o.valid            = 1'b1;
          emit_o.item.coefficient = $signed(a_q);
        end
      end
      ST_I_P_EMITO: begin
        alu_req_o = '{a: c_q, b: asr1(t_q), sub: 1'b0};
        if (out_free_i) begin
          emit_o.valid            = 1'b1;
          emit_o.item.coefficient = $signed(alu_res_i);
          emit_o.item.last_res    = (two_i + IW'(2)) == n_ext;
          i_d                     = i_q + IW'(1);
        end
      end
      // odd line: the trailing even sample is the last low coefficient
      ST_I_T_RD: scr_raddr_o = adr(sn - IW'(1));
      ST_I_T_EMIT: begin
        scr_raddr_o = adr(sn - IW'(1));
        if (out_free_i) begin
          emit_o.valid            = 1'b1;
          emit_o.item.coefficient = $signed(scr_rdata_i);
          emit_o.item.last_res    = 1'b1;
        end
      end
      // plain readout: scratch after forward, line store for short lines
      ST_E_RD: begin
        scr_raddr_o  = k_q[AW-1:0];
        line_raddr_o = k_q[AW-1:0];
      end
      ST_E_EMIT: begin
        scr_raddr_o  = k_q[AW-1:0];
        line_raddr_o = k_q[AW-1:0];
        if (out_free_i) begin
          emit_o.valid            = 1'b1;
          emit_o.item.coefficient = $signed(n_small ? line_rdata_i : scr_rdata_i);
          emit_o.item.last_res    = k_last;
          k_d                     = k_q + NW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      n_q     <= '0;
      ovfl_q  <= 1'b0;
      dir_q   <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      n_q     <= n_d;
      ovfl_q  <= ovfl_d;
      dir_q   <= dir_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    t_q <= t_d;
  end

endmodule

`default_nettype wire

FILE: src/lifting_dwt53_line.sv
// Top level of the one-line reversible 5/3 lifting wavelet transform.
// Depends on ldwt_pkg, ldwt_ram, ldwt_alu and ldwt_seq.
`default_nettype none

// Channel   Signals                                   Moves
// -------   ---------------------------------------   --------------------------------
// in        in_valid_i / in_ready_o / in_data_i       sample + last, line order
// out       out_valid_o / out_ready_i / out_data_o    coefficient + last_res + overflow
// cfg       cfg_we_i / cfg_wdata_i                    direction (0 fwd, 1 inv)
//
// Loading stores each input transaction in the line store while there is room.
// After the last-marked transaction the sequencer runs every lifting step through the
// one shared adder, reading one operand per store per cycle. Forward runs predict
// (read even, right and odd samples, add, subtract), then update (read two high
// values, add, add rounding, add to even), then readout; inverse runs update, then
// predict with emission of each sample pair. Lines under two samples go to readout.
// Input is not ready from the last transaction until the final result has entered
// the output register. Output stalls hold the sequencer in its emit state.
// Reset clears control state only; the stores need no clearing pass.

module lifting_dwt53_line
  import ldwt_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ldwt_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ldwt_out_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Direction register: sampled by the sequencer on the last transaction of a line.
  logic dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  // Store ports.
  logic          line_we, scr_we;
  logic [AW-1:0] line_waddr, line_raddr, scr_waddr, scr_raddr;
  word_t         line_wdata, line_rdata, scr_wdata, scr_rdata;

  // Shared adder.
  ldwt_alu_req_t alu_req;
  word_t         alu_res;

  // Output register handoff.
  ldwt_emit_t emit;
  logic       out_free;
  logic       out_valid_q, out_valid_d;
  ldwt_out_t  out_data_q;

  ldwt_ram #(
    .Width (DataW),
    .Depth (MAX_LEN)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // Scratch holds the low band at the bottom and the high band above it.
  ldwt_ram #(
    .Width (DataW),
    .Depth (MAX_LEN)
  ) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  ldwt_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  ldwt_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .line_we_o    (line_we),
    .line_waddr_o (line_waddr),
    .line_wdata_o (line_wdata),
    .line_raddr_o (line_raddr),
    .line_rdata_i (line_rdata),
    .scr_we_o     (scr_we),
    .scr_waddr_o  (scr_waddr),
    .scr_wdata_o  (scr_wdata),
    .scr_raddr_o  (scr_raddr),
    .scr_rdata_i  (scr_rdata),
    .alu_req_o    (alu_req),
    .alu_res_i    (alu_res),
    .out_free_i   (out_free),
    .emit_o       (emit)
  );

  // The output register takes a new result when empty or when its transaction
  // completes in the same cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_data_q <= emit.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A result is only handed over when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> (!out_valid_q || out_ready_i))
    else $error("result emitted into a full output register");

  // The line closes on its last transaction; no further input until it is emitted.
  a_close_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last) |=> !in_ready_o)
    else $error("input still ready after end of line");

  // Loading and emitting never overlap.
  a_load_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !emit.valid)
    else $error("result emitted while loading");

  // Stored samples stay inside the line store.
  a_line_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_we |-> (32'(line_waddr) < MAX_LEN))
    else $error("line store write beyond depth");

endmodule

`default_nettype wire
